// ----- hw/rtl/hmlp_pkg.sv -----
// Shared constants, codes and control types of the hashed map.
`timescale 1ns / 1ps
package hmlp_pkg;
	localparam int CAPACITY    = 1024;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int VALUE_WIDTH = 32;
	localparam int ID_W        = 32;

	localparam logic [31:0] MUR_M      = 32'h5bd1e995;
	localparam logic [31:0] KEY_LEN    = 32'd8;
	localparam logic [31:0] SEED_RESET = 32'd123;
	localparam logic [31:0] MARK_RESET = 32'hffffffff;

	localparam logic [2:0] HSTEP_LAST = 3'd6;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_GET    = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_SEED   = 1'b0,
		REG_MARKER = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic       cap;
		logic       hstep_en;
		logic [2:0] hstep;
		logic       pinit;
		logic       rd;
		logic       adv;
		logic       wr_add;
		logic       wr_tomb;
		logic       swp_wr;
		logic       cnt_clr;
		logic       fin;
		status_t    res_status;
		logic       res_slot;
		logic       res_found;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  swp_last;
		logic  reserved;
		logic  full;
		logic  probe_empty;
		logic  probe_free;
		logic  probe_match;
		logic  probe_last;
		logic  out_free;
	} sts_t;
endpackage

// ----- hw/rtl/hmlp_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module hmlp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

// ----- hw/rtl/hmlp_ctrl.sv -----
// Controller state machine: hash sequencing, probe loop, clear sweep, result hand-off.
`timescale 1ns / 1ps
module hmlp_ctrl import hmlp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [6:0] {
		S_SWEEP = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_HASH  = 7'b0000100,
		S_CHECK = 7'b0001000,
		S_RD    = 7'b0010000,
		S_CHK   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t  state_q, state_d;
	logic [2:0] hstep_q, hstep_d;
	logic    clr_q, clr_d;
	status_t rstat_q, rstat_d;
	logic    rslot_q, rslot_d;
	logic    rfound_q, rfound_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		hstep_d  = hstep_q;
		clr_d    = clr_q;
		rstat_d  = rstat_q;
		rslot_d  = rslot_q;
		rfound_d = rfound_q;
		cmd      = '0;
		cmd.res_status = rstat_q;
		cmd.res_slot   = rslot_q;
		cmd.res_found  = rfound_q;
		unique case (state_q)
			S_SWEEP: begin
				cmd.swp_wr = 1'b1;
				if (sts.swp_last) begin
					cmd.cnt_clr = 1'b1;
					rstat_d  = ST_OK;
					rslot_d  = 1'b0;
					rfound_d = 1'b0;
					state_d  = clr_q ? S_FIN : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					hstep_d = '0;
					clr_d   = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				// first cycle after capture: clear needs no hash
				if (sts.func == FN_CLEAR) begin
					state_d = S_SWEEP;
				end else begin
					cmd.hstep_en = 1'b1;
					cmd.hstep    = hstep_q;
					hstep_d      = hstep_q + 3'd1;
					if (hstep_q == HSTEP_LAST) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				rslot_d  = 1'b0;
				rfound_d = 1'b0;
				if (sts.reserved) begin
					rstat_d = ST_RESERVED;
					state_d = S_FIN;
				end else if (sts.func == FN_ADD && sts.full) begin
					rstat_d = ST_FULL;
					state_d = S_FIN;
				end else begin
					cmd.pinit = 1'b1;
					state_d   = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				state_d = S_FIN;
				if (sts.func == FN_ADD && sts.probe_free) begin
					cmd.wr_add = 1'b1;
					rstat_d = ST_OK;
					rslot_d = 1'b1;
				end else if (sts.func != FN_ADD && sts.probe_empty) begin
					rstat_d = ST_NOTFOUND;
				end else if (sts.func != FN_ADD && sts.probe_match) begin
					cmd.wr_tomb = (sts.func == FN_REMOVE);
					rstat_d  = ST_OK;
					rslot_d  = 1'b1;
					rfound_d = (sts.func == FN_GET);
				end else if (sts.probe_last) begin
					rstat_d = (sts.func == FN_ADD) ? ST_FULL : ST_NOTFOUND;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_RD;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_SWEEP;
			hstep_q  <= '0;
			clr_q    <= 1'b0;
			rstat_q  <= ST_OK;
			rslot_q  <= 1'b0;
			rfound_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			hstep_q  <= hstep_d;
			clr_q    <= clr_d;
			rstat_q  <= rstat_d;
			rslot_q  <= rslot_d;
			rfound_q <= rfound_d;
		end
	end

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> sts.out_free) else $error("result loaded over a pending transfer");
	a_hash_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HASH) |-> (hstep_q <= HSTEP_LAST)) else $error("hash step overrun");
	a_write_in_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_add || cmd.wr_tomb) |-> (state_q == S_CHK)) else $error("stray table write");
endmodule

// ----- hw/rtl/hmlp_dp.sv -----
// Datapath: config registers, shared hash multiplier, probe pointer, slot stores, result register.
`timescale 1ns / 1ps
module hmlp_dp import hmlp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [1:0]  func,
	input  logic [63:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] found_value,
	output logic [9:0]  slot,
	output logic [10:0] entry_count,
	input  cmd_t        cmd,
	output sts_t        sts
);
	logic [31:0] seed_q, mark_q;
	func_t       func_q;
	logic [63:0] key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [31:0] k_q, h_q, opnd, prod, id;
	logic [IDX_W-1:0] idx_q, n_q, swp_q, ram_addr;
	logic [CNT_W-1:0] cnt_q;
	logic [ID_W-1:0]  id_rd, id_wr;
	logic [VALUE_WIDTH-1:0] val_rd;
	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] found_q;
	logic [IDX_W-1:0] slot_q;
	logic [CNT_W-1:0] ecnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			mark_q <= MARK_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SEED:   seed_q <= cfg_data;
				REG_MARKER: mark_q <= cfg_data;
				default:    seed_q <= seed_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q <= func_t'(func);
			key_q  <= key;
			val_q  <= value[VALUE_WIDTH-1:0];
		end
	end

	// one multiply per step; the step number picks operand and destination
	always_comb begin
		unique case (cmd.hstep)
			3'd0:    opnd = key_q[31:0];
			3'd1:    opnd = k_q ^ (k_q >> 24);
			3'd2:    opnd = seed_q ^ KEY_LEN;
			3'd3:    opnd = key_q[63:32];
			3'd4:    opnd = k_q ^ (k_q >> 24);
			3'd5:    opnd = h_q;
			3'd6:    opnd = h_q ^ (h_q >> 13);
			default: opnd = h_q;
		endcase
	end
	assign prod = opnd * MUR_M;

	always_ff @(posedge clk) begin
		if (cmd.hstep_en) begin
			unique case (cmd.hstep)
				3'd0, 3'd1, 3'd3, 3'd4: k_q <= prod;
				3'd2, 3'd5:             h_q <= prod ^ k_q;
				default:                h_q <= prod;
			endcase
		end
	end
	assign id = h_q ^ (h_q >> 15);

	always_ff @(posedge clk) begin
		if (cmd.pinit) begin
			idx_q <= id[IDX_W-1:0];
			n_q   <= '0;
		end else if (cmd.adv) begin
			idx_q <= idx_q + 1'b1;
			n_q   <= n_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swp_q <= '0;
		end else if (cmd.cap) begin
			swp_q <= '0;
		end else if (cmd.swp_wr) begin
			swp_q <= swp_q + 1'b1;
		end
	end

	assign ram_addr = cmd.swp_wr ? swp_q : idx_q;
	assign id_wr    = cmd.swp_wr ? '0 : (cmd.wr_add ? id : mark_q);

	hmlp_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_ids (
		.clk   (clk),
		.we    (cmd.swp_wr | cmd.wr_add | cmd.wr_tomb),
		.re    (cmd.rd),
		.addr  (ram_addr),
		.wdata (id_wr),
		.rdata (id_rd)
	);

	hmlp_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_vals (
		.clk   (clk),
		.we    (cmd.wr_add),
		.re    (cmd.rd),
		.addr  (idx_q),
		.wdata (val_q),
		.rdata (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.wr_add) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.wr_tomb && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// result register; next item may start while this one waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			status_q <= cmd.res_status;
			found_q  <= cmd.res_found ? 32'(val_rd) : '0;
			slot_q   <= cmd.res_slot ? idx_q : '0;
			ecnt_q   <= cnt_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign slot        = slot_q;
	assign entry_count = ecnt_q;

	assign sts.func        = func_q;
	assign sts.swp_last    = (swp_q == IDX_W'(CAPACITY - 1));
	assign sts.reserved    = (id == '0) || (id == mark_q);
	assign sts.full        = (cnt_q >= CNT_W'(CAPACITY));
	assign sts.probe_empty = (id_rd == '0);
	assign sts.probe_free  = (id_rd == '0) || (id_rd == mark_q);
	assign sts.probe_match = (id_rd == id);
	assign sts.probe_last  = (n_q == IDX_W'(CAPACITY - 1));
	assign sts.out_free    = !out_valid_q || !out_stall;

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.swp_wr, cmd.wr_add, cmd.wr_tomb})) else $error("colliding table writes");
	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_add |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("add did not count");
endmodule

// ----- hw/rtl/hashed_map_linear_probe_top.sv -----
// Top level of the hashed map with linear probing.
`timescale 1ns / 1ps
// One operation at a time. A key is hashed step by step through one shared 32x32
// multiplier, then each probe uses the single port of the id store (address, then
// registered read). Add, remove and get probe at most 1024 slots; a reserved hash
// id, or an add to a full table, ends with no probe. Clear, and also the clearing
// pass after reset, sweeps the id store one slot a cycle, during which no item is
// taken. A finished result waits in an output register while the next item is
// already taken; a new result is not loaded until the waiting one has been
// transferred, and the block holds off its input meanwhile.
module hashed_map_linear_probe_top import hmlp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [63:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] found_value,
	output logic [9:0]  slot,
	output logic [10:0] entry_count
);
	cmd_t cmd;
	sts_t sts;

	hmlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	hmlp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.func        (func),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found_value (found_value),
		.slot        (slot),
		.entry_count (entry_count),
		.cmd         (cmd),
		.sts         (sts)
	);
endmodule
